// ----- rtl/srarq_pkg.sv -----
`timescale 1ns / 1ps
package srarq_pkg;
	localparam int SEQ_W = 4;
	localparam int SLOT_W = 3;
	localparam logic [SEQ_W-1:0] SEQ_MAX = 4'd15;
	localparam logic [SEQ_W-1:0] NR_BUFS = 4'd8;

	typedef enum logic [2:0] {
		CMD_UPPER = 3'd0, CMD_LINK = 3'd1, CMD_FRAME = 3'd2,
		CMD_DTMO = 3'd3, CMD_ATMO = 3'd4
	} cmd_e;

	typedef enum logic [1:0] {KIND_DATA = 2'd0, KIND_ACK = 2'd1, KIND_NAK = 2'd2} kind_e;

	typedef enum logic [2:0] {
		ACT_SEND = 3'd0, ACT_NAK = 3'd1, ACT_ACK = 3'd2, ACT_DELIVER = 3'd3,
		ACT_START = 3'd4, ACT_STOP = 3'd5, ACT_STATUS = 3'd6
	} act_e;

	// datapath command from the controller
	typedef struct packed {
		logic       latch;      // capture input word
		logic       emit;       // load output register
		logic [2:0] act;
		logic       do_upper;
		logic       do_link;
		logic       do_nak;     // send nak and clear nak_allowed
		logic       do_mark;    // set arrived bit of frame seq
		logic       do_deliver; // deliver receive_low and advance
		logic       do_nakdata; // resend ack+1
		logic       do_stop;    // stop oldest and advance
		logic       do_tmo;     // resend timer slot
	} dp_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic [2:0] cmd;
		logic       crc_bad;
		logic [1:0] kind;
		logic       can_send;
		logic       nak_allowed;
		logic       seq_is_low;
		logic       mark_ok;
		logic       low_arrived;
		logic       nakdata_ok;
		logic       ack_in_win;
		logic       out_busy;
	} dp_sts_t;

	function automatic logic in_window(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
		logic [SEQ_W-1:0] c);
		return (a <= b && b < c) || (c < a && a <= b) || (c < a && b < c);
	endfunction

	function automatic logic [SEQ_W-1:0] seq_inc(logic [SEQ_W-1:0] s);
		return (s < SEQ_MAX) ? s + 4'd1 : 4'd0;
	endfunction
endpackage

// ----- rtl/srarq_dp.sv -----
`timescale 1ns / 1ps
module srarq_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [16:0]            in_word,
	input  srarq_pkg::dp_cmd_t     cmd,
	output srarq_pkg::dp_sts_t     sts,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata,
	output logic                   m_tlast
);
	import srarq_pkg::*;

	logic [16:0] in_q;
	logic [3:0] nts_q, oldest_q, rlow_q, rhigh_q, outst_q;
	logic [7:0] arr_q;
	logic nak_ok_q, link_q;
	logic [3:0] fseq, fack, s_nak, s_tmo, s_sel;
	logic [2:0] tslot;
	logic ov_q;
	logic [15:0] od_q;
	logic ol_q;
	logic [3:0] seq_o;
	logic [2:0] slot_o;
	logic net_o;
	logic send;

	assign fseq = in_q[9:6];
	assign fack = in_q[13:10];
	assign tslot = in_q[16:14];
	assign s_nak = fack + 4'd1;
	assign s_tmo = in_window(oldest_q, {1'b0, tslot}, nts_q) ? {1'b0, tslot} :
		{1'b0, tslot} + NR_BUFS;
	assign send = cmd.do_upper | cmd.do_nakdata | cmd.do_tmo;
	assign s_sel = cmd.do_upper ? nts_q : (cmd.do_nakdata ? s_nak : s_tmo);

	assign sts.cmd = in_q[2:0];
	assign sts.crc_bad = in_q[3];
	assign sts.kind = in_q[5:4];
	assign sts.can_send = (outst_q < NR_BUFS) && link_q;
	assign sts.nak_allowed = nak_ok_q;
	assign sts.seq_is_low = (fseq == rlow_q);
	assign sts.mark_ok = in_window(rlow_q, fseq, rhigh_q) && !arr_q[fseq[2:0]];
	assign sts.low_arrived = arr_q[rlow_q[2:0]];
	assign sts.nakdata_ok = in_window(oldest_q, s_nak, nts_q);
	assign sts.ack_in_win = in_window(oldest_q, fack, nts_q);
	assign sts.out_busy = ov_q;

	// select output fields for the action being emitted
	always_comb begin
		seq_o = 4'd0;
		slot_o = 3'd0;
		net_o = sts.can_send;
		if (send) begin
			seq_o = s_sel;
			slot_o = s_sel[2:0];
			// a data frame drops link ready before the word is formed
			net_o = 1'b0;
		end else if (cmd.do_deliver) begin
			slot_o = rlow_q[2:0];
		end else if (cmd.do_stop) begin
			slot_o = oldest_q[2:0];
			// outstanding count is decremented before the word is formed
			net_o = (outst_q <= NR_BUFS) && link_q;
		end else if (cmd.act == ACT_STATUS) begin
			seq_o = nts_q;
		end
	end

	// update link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nts_q <= '0; oldest_q <= '0; rlow_q <= '0; rhigh_q <= NR_BUFS;
			outst_q <= '0; arr_q <= '0; nak_ok_q <= 1'b1; link_q <= 1'b0;
		end else begin
			if (cmd.do_link) link_q <= 1'b1;
			if (send) link_q <= 1'b0;
			if (cmd.do_upper) begin
				outst_q <= outst_q + 4'd1;
				nts_q <= seq_inc(nts_q);
			end
			if (cmd.do_nak) nak_ok_q <= 1'b0;
			if (cmd.do_mark) arr_q[fseq[2:0]] <= 1'b1;
			if (cmd.do_deliver) begin
				arr_q[rlow_q[2:0]] <= 1'b0;
				nak_ok_q <= 1'b1;
				rlow_q <= seq_inc(rlow_q);
				rhigh_q <= seq_inc(rhigh_q);
			end
			if (cmd.do_stop) begin
				if (outst_q != 4'd0) outst_q <= outst_q - 4'd1;
				oldest_q <= seq_inc(oldest_q);
			end
		end
	end

	// hold output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) in_q <= in_word;
		if (cmd.emit) begin
			od_q <= {1'b0, net_o, slot_o, rlow_q - 4'd1, seq_o, cmd.act};
			ol_q <= (cmd.act == ACT_STATUS);
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata = od_q;
	assign m_tlast = ol_q;
endmodule

// ----- rtl/srarq_ctrl.sv -----
`timescale 1ns / 1ps
module srarq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  srarq_pkg::dp_sts_t  sts,
	output srarq_pkg::dp_cmd_t  cmd
);
	import srarq_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001, ST_DISP = 6'b000010, ST_MARK = 6'b000100,
		ST_DELIV = 6'b001000, ST_NAKD = 6'b010000, ST_STOP = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic start_q, start_d;
	logic stall;

	assign s_tready = (state_q == ST_IDLE);
	assign stall = sts.out_busy;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		start_d = start_q;
		cmd.latch = s_tready && s_tvalid;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DISP;
			end
			ST_DISP: begin
				if (!stall) begin
					cmd.emit = 1'b1;
					cmd.act = ACT_STATUS;
					state_d = ST_IDLE;
					start_d = 1'b0;
					case (sts.cmd)
						CMD_UPPER: begin
							if (sts.can_send) begin
								cmd.act = ACT_SEND; cmd.do_upper = 1'b1;
							end
						end
						CMD_LINK: begin
							cmd.emit = 1'b0; cmd.do_link = 1'b1; state_d = ST_STOP;
						end
						CMD_DTMO: begin
							cmd.act = ACT_SEND; cmd.do_tmo = 1'b1;
						end
						CMD_ATMO: begin
							cmd.act = ACT_ACK;
						end
						CMD_FRAME: begin
							if (sts.crc_bad) begin
								if (sts.nak_allowed) begin
									cmd.act = ACT_NAK; cmd.do_nak = 1'b1;
								end else cmd.emit = 1'b0;
								state_d = ST_STOP;
							end else if (sts.kind == KIND_DATA) begin
								if (!sts.seq_is_low && sts.nak_allowed) begin
									cmd.act = ACT_NAK; cmd.do_nak = 1'b1;
								end else begin
									cmd.emit = 1'b0; start_d = 1'b1;
								end
								state_d = ST_MARK;
							end else begin
								cmd.emit = 1'b0;
								state_d = (sts.kind == KIND_NAK) ? ST_NAKD : ST_STOP;
							end
						end
						default: ;
					endcase
					// a status-only pass after commands that already acted
					if (state_d == ST_IDLE && cmd.act != ACT_STATUS) state_d = ST_STOP;
				end
			end
			ST_MARK: begin
				if (sts.mark_ok) cmd.do_mark = 1'b1;
				state_d = ST_DELIV;
			end
			ST_DELIV: begin
				if (!stall) begin
					if (sts.low_arrived) begin
						cmd.emit = 1'b1; cmd.act = ACT_DELIVER; cmd.do_deliver = 1'b1;
						start_d = 1'b1;
					end else begin
						if (start_q) begin
							cmd.emit = 1'b1; cmd.act = ACT_START; start_d = 1'b0;
						end
						state_d = ST_STOP;
					end
				end
			end
			ST_NAKD: begin
				if (!stall) begin
					if (sts.nakdata_ok) begin
						cmd.emit = 1'b1; cmd.act = ACT_SEND; cmd.do_nakdata = 1'b1;
					end
					state_d = ST_STOP;
				end
			end
			ST_STOP: begin
				if (!stall) begin
					cmd.emit = 1'b1;
					if (sts.cmd == CMD_FRAME && !sts.crc_bad && sts.ack_in_win) begin
						cmd.act = ACT_STOP; cmd.do_stop = 1'b1;
					end else begin
						cmd.act = ACT_STATUS; state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= start_d;
		end
	end
endmodule

// ----- rtl/selective_repeat_arq_controller_top.sv -----
// Flow: an event word is taken only in idle and decoded in the dispatch state, which may
// emit the first word; data frames then pass the mark and deliver states, NAK frames the
// nakdata state, and the stop state ends with a status word; each word is emitted only
// once the output register has emptied.
// Throughput: one event at a time; back-pressure on m_tready stalls the controller.
// Reset: arst_n clears all window state asynchronously; receive_high to 8, nak allowed.
`timescale 1ns / 1ps
module selective_repeat_arq_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[2:0] crc_bad[3] rx_kind[5:4] rx_seq[9:6] rx_ack[13:10] timer_slot[16:14]
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// action[2:0] seq_out[6:3] ack_out[10:7] slot[13:11] net_enable[14]
	output logic [15:0] m_tdata,
	output logic        m_tlast
);
	import srarq_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	srarq_ctrl u_ctrl (.clk, .arst_n, .s_tvalid, .s_tready, .sts, .cmd);
	srarq_dp u_dp (.clk, .arst_n, .in_word(s_tdata[16:0]), .cmd, .sts,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast);
endmodule
